>>> rtl/core/call_argument_location_assigner_defines.svh
// Assertion macros for the call argument location assigner checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CALL_ARGUMENT_LOCATION_ASSIGNER_DEFINES_SVH
`define CALL_ARGUMENT_LOCATION_ASSIGNER_DEFINES_SVH

// Same-cycle implication.
`define CALA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CALA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cala_pkg.sv
// Shared types and constants for the call argument location assigner.
// No dependencies.
package cala_pkg;

    typedef struct packed {
        logic [11:0] arg_len;
        logic [2:0]  align_exp;
        logic [1:0]  class_low;
        logic [1:0]  class_high;
        logic        last_arg;
    } t_in;

    typedef struct packed {
        logic [3:0]  loc_kind;
        logic [2:0]  first_reg;
        logic [2:0]  second_reg;
        logic [15:0] slot_offset;
        logic        offset_overflow;
        logic        last_out;
    } t_out;

    typedef struct packed {
        logic        force_stack;
        logic [1:0]  need_gpr;
        logic [1:0]  need_sse;
        logic        first_gpr;
        logic        second_gpr;
        logic        two_regs;
        logic [3:0]  reg_kind;
        logic [3:0]  stack_kind;
        logic [12:0] size_rnd;
        logic [6:0]  align_mask;
        logic        last;
    } t_work;

    localparam logic [1:0] CLASS_INT = 2'd0;
    localparam logic [1:0] CLASS_SSE = 2'd1;

    localparam logic [3:0] KIND_GPR       = 4'd0;
    localparam logic [3:0] KIND_SSE       = 4'd1;
    localparam logic [3:0] KIND_GPR_GPR   = 4'd2;
    localparam logic [3:0] KIND_GPR_SSE   = 4'd3;
    localparam logic [3:0] KIND_SSE_GPR   = 4'd4;
    localparam logic [3:0] KIND_SSE_SSE   = 4'd5;
    localparam logic [3:0] KIND_STACK     = 4'd6;
    localparam logic [3:0] KIND_PTR_GPR   = 4'd7;
    localparam logic [3:0] KIND_PTR_STACK = 4'd8;

    localparam logic [11:0] LARGE_LEN    = 12'd24;
    localparam logic [11:0] ONE_CHUNK    = 12'd8;
    localparam logic [12:0] PTR_SIZE     = 13'd8;
    localparam logic [6:0]  PTR_MASK     = 7'd7;
    localparam logic [15:0] OFFSET_INIT  = 16'd16;
    localparam logic [15:0] OFFSET_MAX   = 16'hFFFF;

endpackage

>>> rtl/core/cala_fifo.sv
// Generic register-based queue with registered entries.
// No dependencies.
module cala_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/cala_front.sv
// Front end: accepts argument transactions and classifies them into work entries.
// Depends on cala_pkg.
module cala_front (
    input  logic            i_in_valid,
    input  cala_pkg::t_in   i_in_data,
    input  logic            i_full,
    output logic            o_in_stall,
    output logic            o_push,
    output cala_pkg::t_work o_work
);
    import cala_pkg::*;

    logic        is_mem;
    logic        is_large;
    logic        is_one;
    logic        c1_int;
    logic        c2_int;
    logic [12:0] len_rnd;
    logic [7:0]  align_pow;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    assign is_mem    = i_in_data.class_low[1] || i_in_data.class_high[1];
    assign is_large  = (i_in_data.arg_len >= LARGE_LEN);
    assign is_one    = (i_in_data.arg_len <= ONE_CHUNK);
    assign c1_int    = (i_in_data.class_low == CLASS_INT);
    assign c2_int    = (i_in_data.class_high == CLASS_INT);
    assign len_rnd   = ({1'b0, i_in_data.arg_len} + 13'd7) & ~13'd7;
    assign align_pow = 8'd1 << i_in_data.align_exp;

    always_comb begin
        o_work             = '0;
        o_work.last        = i_in_data.last_arg;
        o_work.stack_kind  = KIND_STACK;
        o_work.size_rnd    = len_rnd;
        o_work.align_mask  = 7'(align_pow - 8'd1);
        if (is_mem) begin
            o_work.force_stack = 1'b1;
        end else if (is_large) begin
            o_work.need_gpr   = 2'd1;
            o_work.first_gpr  = 1'b1;
            o_work.reg_kind   = KIND_PTR_GPR;
            o_work.stack_kind = KIND_PTR_STACK;
            o_work.size_rnd   = PTR_SIZE;
            o_work.align_mask = PTR_MASK;
        end else if (is_one) begin
            o_work.need_gpr  = {1'b0, c1_int};
            o_work.need_sse  = {1'b0, !c1_int};
            o_work.first_gpr = c1_int;
            o_work.reg_kind  = c1_int ? KIND_GPR : KIND_SSE;
        end else begin
            o_work.need_gpr   = 2'(c1_int) + 2'(c2_int);
            o_work.need_sse   = 2'(!c1_int) + 2'(!c2_int);
            o_work.first_gpr  = c1_int;
            o_work.second_gpr = c2_int;
            o_work.two_regs   = 1'b1;
            o_work.reg_kind   = KIND_GPR_GPR + {2'b00, !c1_int, !c2_int};
        end
    end

endmodule

>>> rtl/core/cala_back.sv
// Back end: allocates registers and stack slots and holds the result register.
// Depends on cala_pkg.
module cala_back #(
    parameter int GPR_COUNT = 6,
    parameter int SSE_COUNT = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  cala_pkg::t_work i_work,
    output logic            o_pop,
    output logic            o_out_valid,
    output cala_pkg::t_out  o_out_data,
    input  logic            i_out_stall
);
    import cala_pkg::*;

    localparam int GW = $clog2(GPR_COUNT + 1);
    localparam int SW = $clog2(SSE_COUNT + 1);

    logic [GW-1:0] r_gpr, n_gpr;
    logic [SW-1:0] r_sse, n_sse;
    logic [15:0]   r_off, n_off;
    logic          r_out_valid;
    t_out          r_out, n_out;

    logic          fits;
    logic [GW:0]   gpr_need_sum;
    logic [SW:0]   sse_need_sum;
    logic [GW+2:0] gpr_a;
    logic [GW+2:0] gpr_b;
    logic [SW+2:0] sse_a;
    logic [SW+2:0] sse_b;
    logic [2:0]    reg1;
    logic [2:0]    reg2;
    logic [16:0]   start_sum;
    logic [16:0]   start_al;
    logic          ovf_start;
    logic [15:0]   start_off;
    logic [16:0]   end_sum;
    logic          ovf_end;
    logic [15:0]   end_off;

    assign o_pop       = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign gpr_need_sum = {1'b0, r_gpr} + (GW+1)'(i_work.need_gpr);
    assign sse_need_sum = {1'b0, r_sse} + (SW+1)'(i_work.need_sse);
    assign fits = !i_work.force_stack
               && (gpr_need_sum <= (GW+1)'(GPR_COUNT))
               && (sse_need_sum <= (SW+1)'(SSE_COUNT));

    assign gpr_a = (GW+3)'(r_gpr);
    assign gpr_b = (GW+3)'(r_gpr) + (GW+3)'(i_work.first_gpr);
    assign sse_a = (SW+3)'(r_sse);
    assign sse_b = (SW+3)'(r_sse) + (SW+3)'(!i_work.first_gpr);
    assign reg1  = i_work.first_gpr ? gpr_a[2:0] : sse_a[2:0];
    assign reg2  = !i_work.two_regs ? 3'd0 :
                   (i_work.second_gpr ? gpr_b[2:0] : sse_b[2:0]);

    assign start_sum = {1'b0, r_off} + 17'(i_work.align_mask);
    assign start_al  = start_sum & ~17'(i_work.align_mask);
    assign ovf_start = start_al[16];
    assign start_off = ovf_start ? OFFSET_MAX : start_al[15:0];
    assign end_sum   = {1'b0, start_off} + 17'(i_work.size_rnd);
    assign ovf_end   = end_sum[16];
    assign end_off   = ovf_end ? OFFSET_MAX : end_sum[15:0];

    always_comb begin
        n_gpr = r_gpr;
        n_sse = r_sse;
        n_off = r_off;
        n_out = r_out;
        if (o_pop) begin
            n_out.last_out = i_work.last;
            if (fits) begin
                n_out.loc_kind        = i_work.reg_kind;
                n_out.first_reg       = reg1;
                n_out.second_reg      = reg2;
                n_out.slot_offset     = '0;
                n_out.offset_overflow = 1'b0;
                n_gpr = gpr_need_sum[GW-1:0];
                n_sse = sse_need_sum[SW-1:0];
            end else begin
                n_out.loc_kind        = i_work.stack_kind;
                n_out.first_reg       = 3'd0;
                n_out.second_reg      = 3'd0;
                n_out.slot_offset     = start_off;
                n_out.offset_overflow = ovf_start || ovf_end;
                n_off = end_off;
            end
            if (i_work.last) begin
                n_gpr = '0;
                n_sse = '0;
                n_off = OFFSET_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpr       <= '0;
            r_sse       <= '0;
            r_off       <= OFFSET_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_gpr       <= n_gpr;
            r_sse       <= n_sse;
            r_off       <= n_off;
            r_out_valid <= o_pop || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

>>> rtl/core/call_argument_location_assigner.sv
// An accepted argument is written into the queue, then moved into the result
// register, which raises o_out_valid; a stalled result holds later ones queued.
// Throughput: one argument per cycle when not stalled; the stack path (align-up
// add, then the size add with saturation) in the back end sets the cycle.
// A two-entry queue decouples classification from allocation.
// Reset (synchronous, active low): queue empty, no result pending,
// next GPR 0, next SSE 0, stack offset 16.
module call_argument_location_assigner #(
    parameter int GPR_COUNT = 6,
    parameter int SSE_COUNT = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  cala_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output cala_pkg::t_out o_out_data,
    input  logic           i_out_stall
);
    import cala_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_work front_work;
    t_work back_work;

    cala_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_work     (front_work)
    );

    cala_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (back_work),
        .o_empty (empty)
    );

    cala_back #(
        .GPR_COUNT (GPR_COUNT),
        .SSE_COUNT (SSE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_work      (back_work),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> rtl/core/cala_checker.sv
// Port-level checks for the call argument location assigner, bound to the top.
// Depends on cala_pkg and call_argument_location_assigner_defines.svh.
`include "call_argument_location_assigner_defines.svh"

module cala_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input cala_pkg::t_out o_out_data,
    input logic           i_out_stall
);
    import cala_pkg::*;

    logic is_reg_place;
    logic is_stack_place;
    logic is_ptr_slot;
    logic no_offset;
    logic no_regs;
    logic slot_aligned;

    assign is_reg_place   = o_out_valid && (o_out_data.loc_kind < KIND_STACK
                                            || o_out_data.loc_kind == KIND_PTR_GPR);
    assign is_stack_place = o_out_valid && (o_out_data.loc_kind == KIND_STACK
                                            || o_out_data.loc_kind == KIND_PTR_STACK);
    assign is_ptr_slot    = o_out_valid && o_out_data.loc_kind == KIND_PTR_STACK;
    assign no_offset      = o_out_data.slot_offset == 16'd0 && !o_out_data.offset_overflow;
    assign no_regs        = o_out_data.first_reg == 3'd0 && o_out_data.second_reg == 3'd0;
    assign slot_aligned   = o_out_data.offset_overflow || o_out_data.slot_offset[2:0] == 3'd0;

    `CALA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")
    `CALA_ASSERT_NOW(a_reg_no_offset, is_reg_place, no_offset, "register placement has an offset")
    `CALA_ASSERT_NOW(a_stack_no_reg, is_stack_place, no_regs, "stack placement has registers")
    `CALA_ASSERT_NOW(a_ptr_aligned, is_ptr_slot, slot_aligned, "pointer slot not 8-byte aligned")

endmodule

bind call_argument_location_assigner cala_checker u_cala_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

>>> sim/call_argument_location_assigner_test.sv
// Self-checking testbench for call_argument_location_assigner: directed and random
// argument lists, with a built-in placement predictor checked against every result.
// Depends on cala_pkg and the call_argument_location_assigner RTL.
module call_argument_location_assigner_test;
    import cala_pkg::*;

    localparam int         GPR_COUNT  = 6;
    localparam int         SSE_COUNT  = 8;
    localparam logic [1:0] CLASS_MEM  = 2'd2;
    localparam logic [1:0] CLASS_RSVD = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;
    logic out_stall = 1'b0;

    int   send_idle_pct = 13;
    int   recv_idle_pct = 68;
    int   mismatch_count = 0;

    int   gpr_next = 0;
    int   sse_next = 0;
    int   frame_off = OFFSET_INIT;
    t_out expected_locations[$];

    call_argument_location_assigner #(
        .GPR_COUNT(GPR_COUNT),
        .SSE_COUNT(SSE_COUNT)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("call_argument_location_assigner_test: FAIL");
        $finish;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void stack_alloc(input int size, input int aexp,
                                        output logic [15:0] off, output logic ovf);
        int mask;
        int start;
        int stop;
        mask  = (1 << aexp) - 1;
        start = (frame_off + mask) & ~mask;
        ovf   = 1'b0;
        if (start > OFFSET_MAX) begin
            start = OFFSET_MAX;
            ovf   = 1'b1;
        end
        stop = start + ((size + 7) & ~7);
        if (stop > OFFSET_MAX) begin
            stop = OFFSET_MAX;
            ovf  = 1'b1;
        end
        frame_off = stop;
        off = start[15:0];
    endfunction

    function automatic t_out place_argument(input t_in a);
        t_out r;
        logic to_stack;
        int   len;
        int   need_int;
        int   need_vec;
        r        = '0;
        r.last_out = a.last_arg;
        len      = a.arg_len;
        to_stack = 1'b0;
        if (a.class_low >= CLASS_MEM || a.class_high >= CLASS_MEM) begin
            to_stack = 1'b1;
        end else if (len >= 24) begin
            if (gpr_next < GPR_COUNT) begin
                r.loc_kind  = KIND_PTR_GPR;
                r.first_reg = gpr_next[2:0];
                gpr_next++;
            end else begin
                r.loc_kind = KIND_PTR_STACK;
                stack_alloc(8, 3, r.slot_offset, r.offset_overflow);
            end
        end else if (len <= 8) begin
            if (a.class_low == CLASS_INT) begin
                if (gpr_next + 1 > GPR_COUNT) begin
                    to_stack = 1'b1;
                end else begin
                    r.loc_kind  = KIND_GPR;
                    r.first_reg = gpr_next[2:0];
                    gpr_next++;
                end
            end else begin
                if (sse_next + 1 > SSE_COUNT) begin
                    to_stack = 1'b1;
                end else begin
                    r.loc_kind  = KIND_SSE;
                    r.first_reg = sse_next[2:0];
                    sse_next++;
                end
            end
        end else begin
            need_int = (a.class_low == CLASS_INT) + (a.class_high == CLASS_INT);
            need_vec = 2 - need_int;
            if (gpr_next + need_int > GPR_COUNT || sse_next + need_vec > SSE_COUNT) begin
                to_stack = 1'b1;
            end else begin
                if (a.class_low == CLASS_INT) begin
                    r.first_reg = gpr_next[2:0];
                    gpr_next++;
                end else begin
                    r.first_reg = sse_next[2:0];
                    sse_next++;
                end
                if (a.class_high == CLASS_INT) begin
                    r.second_reg = gpr_next[2:0];
                    gpr_next++;
                end else begin
                    r.second_reg = sse_next[2:0];
                    sse_next++;
                end
                case ({a.class_low == CLASS_SSE, a.class_high == CLASS_SSE})
                    2'b00: r.loc_kind = KIND_GPR_GPR;
                    2'b01: r.loc_kind = KIND_GPR_SSE;
                    2'b10: r.loc_kind = KIND_SSE_GPR;
                    default: r.loc_kind = KIND_SSE_SSE;
                endcase
            end
        end
        if (to_stack) begin
            r.loc_kind   = KIND_STACK;
            r.first_reg  = '0;
            r.second_reg = '0;
            stack_alloc(len, a.align_exp, r.slot_offset, r.offset_overflow);
        end
        if (a.last_arg) begin
            gpr_next  = 0;
            sse_next  = 0;
            frame_off = OFFSET_INIT;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_locations.size() == 0) begin
                report_mismatch("unexpected transaction, loc_kind", out_data.loc_kind, -1);
            end else begin
                want = expected_locations.pop_front();
                if (out_data.loc_kind !== want.loc_kind)
                    report_mismatch("loc_kind", out_data.loc_kind, want.loc_kind);
                if (out_data.first_reg !== want.first_reg)
                    report_mismatch("first_reg", out_data.first_reg, want.first_reg);
                if (out_data.second_reg !== want.second_reg)
                    report_mismatch("second_reg", out_data.second_reg, want.second_reg);
                if (out_data.slot_offset !== want.slot_offset)
                    report_mismatch("slot_offset", out_data.slot_offset, want.slot_offset);
                if (out_data.offset_overflow !== want.offset_overflow)
                    report_mismatch("offset_overflow", out_data.offset_overflow,
                                    want.offset_overflow);
                if (out_data.last_out !== want.last_out)
                    report_mismatch("last_out", out_data.last_out, want.last_out);
            end
        end
    end

    function automatic t_in make_arg(input int len, input int aexp, input logic [1:0] cl,
                                     input logic [1:0] ch, input logic last);
        t_in a;
        a.arg_len    = len[11:0];
        a.align_exp  = aexp[2:0];
        a.class_low  = cl;
        a.class_high = ch;
        a.last_arg   = last;
        return a;
    endfunction

    task automatic send_arg(input t_in a);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= a;
        do @(posedge clk); while (in_stall);
        expected_locations.push_back(place_argument(a));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_locations.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_register_kinds();
        send_arg(make_arg(8, 3, CLASS_INT, CLASS_INT, 1'b0));
        send_arg(make_arg(0, 0, CLASS_SSE, CLASS_INT, 1'b0));
        send_arg(make_arg(9, 1, CLASS_INT, CLASS_INT, 1'b0));
        send_arg(make_arg(16, 2, CLASS_INT, CLASS_SSE, 1'b0));
        send_arg(make_arg(23, 4, CLASS_SSE, CLASS_INT, 1'b0));
        send_arg(make_arg(12, 5, CLASS_SSE, CLASS_SSE, 1'b1));
    endtask

    task automatic test_stack_kinds();
        send_arg(make_arg(5, 0, CLASS_MEM, CLASS_INT, 1'b0));
        send_arg(make_arg(17, 6, CLASS_INT, CLASS_MEM, 1'b0));
        send_arg(make_arg(1, 7, CLASS_RSVD, CLASS_SSE, 1'b0));
        send_arg(make_arg(40, 2, CLASS_SSE, CLASS_RSVD, 1'b0));
        send_arg(make_arg(24, 0, CLASS_INT, CLASS_SSE, 1'b0));
        send_arg(make_arg(4095, 7, CLASS_SSE, CLASS_SSE, 1'b0));
        for (int i = 0; i < 4; i++)
            send_arg(make_arg(4, 0, CLASS_INT, CLASS_SSE, 1'b0));
        send_arg(make_arg(8, 3, CLASS_INT, CLASS_INT, 1'b0));
        send_arg(make_arg(100, 0, CLASS_INT, CLASS_INT, 1'b0));
        send_arg(make_arg(10, 5, CLASS_INT, CLASS_SSE, 1'b1));
    endtask

    task automatic test_offset_overflow();
        for (int i = 0; i < 17; i++)
            send_arg(make_arg(4095, 0, CLASS_MEM, CLASS_MEM, 1'b0));
        send_arg(make_arg(0, 7, CLASS_RSVD, CLASS_RSVD, 1'b0));
        send_arg(make_arg(30, 0, CLASS_INT, CLASS_INT, 1'b1));
        wait_drained();
    endtask

    function automatic t_in random_arg(input logic last);
        t_in a;
        int  sel;
        sel = $urandom_range(99);
        if ($urandom_range(99) < 10) begin
            a = t_in'($urandom);
        end else begin
            if (sel < 50)
                a.arg_len = 12'($urandom_range(23));
            else if (sel < 75)
                a.arg_len = 12'($urandom_range(64, 24));
            else
                a.arg_len = 12'($urandom_range(4095));
            a.align_exp  = 3'($urandom_range(7));
            a.class_low  = ($urandom_range(99) < 85) ? 2'($urandom_range(1))
                                                     : 2'($urandom_range(3, 2));
            a.class_high = ($urandom_range(99) < 85) ? 2'($urandom_range(1))
                                                     : 2'($urandom_range(3, 2));
            a.last_arg   = last;
        end
        return a;
    endfunction

    task automatic test_random_calls(input int n_items, input int send_pct, input int recv_pct);
        int   sent;
        int   nargs;
        t_in  a;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 4) begin
                nargs = $urandom_range(24, 16);
                for (int k = 0; k < nargs; k++) begin
                    a = make_arg($urandom_range(4095, 3000), $urandom_range(7),
                                 CLASS_MEM, 2'($urandom_range(3)), k == nargs - 1);
                    send_arg(a);
                end
            end else begin
                nargs = $urandom_range(12, 1);
                for (int k = 0; k < nargs; k++)
                    send_arg(random_arg(k == nargs - 1));
            end
            sent += nargs;
        end
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_register_kinds();
        test_stack_kinds();
        test_offset_overflow();
        test_random_calls(540, 13, 68);
        wait_drained();
        test_random_calls(540, 68, 13);
        test_random_calls(540, 0, 0);
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("call_argument_location_assigner_test: PASS");
        end else begin
            $display("call_argument_location_assigner_test: FAIL");
        end
        $finish;
    end

endmodule
